// File: rtl/fcr_pkg.sv
package fcr_pkg;

	// default number of payload bytes held
	localparam int PAYLOAD_DEPTH_DEF = 32;

	// framing bytes
	localparam logic [7:0] HDR_BYTE     = 8'hFE;
	localparam logic [7:0] FOOTER_RESET = 8'hFA;

	// parser phase, also shown on the result
	typedef enum logic [2:0] {
		PH_HDR1 = 3'd0,
		PH_HDR2 = 3'd1,
		PH_LEN  = 3'd2,
		PH_DATA = 3'd3,
		PH_FOOT = 3'd4,
		PH_DONE = 3'd5
	} phase_t;

	// error codes on the result
	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_BAD_FOOTER = 3'd1,
		ERR_BAD_LENGTH = 3'd2,
		ERR_AFTER_DONE = 3'd3,
		ERR_NO_FRAME   = 3'd4
	} err_t;

	// input commands
	typedef enum logic [1:0] {
		CMD_RECEIVE = 2'd0,
		CMD_FORWARD = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

endpackage

// File: rtl/fcr_ram.sv
module fcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/framed_command_receiver.sv
// channel | signals                    | beat moves
// --------+----------------------------+----------------------------------------
// in      | in_valid, in_ready         | cmd, rx_byte
// out     | out_valid, out_ready       | phase, frame_done, error_code, tx_valid,
//         |                            | tx_byte, last
// cfg     | cfg_valid, cfg_ready       | cfg_data (footer byte), always ready
//
// receive, restart and refused commands each give one out beat;
// with out_ready high and no forward running, one in beat is taken every cycle.
// a forward gives length+3 out beats from the output register, one per cycle
// while out_ready is high, payload read ahead from the payload RAM; in_ready
// stays low until the footer beat is loaded.
// arst_n clears the parser to hunting and the footer to 0xFA; the payload RAM
// is not cleared. a stalled out beat holds the output register and in_ready.
module framed_command_receiver import fcr_pkg::*; #(
	parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] phase,
	output logic       frame_done,
	output logic [2:0] error_code,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam int FILL_W = $clog2(PAYLOAD_DEPTH + 1);
	localparam int POS_W  = $clog2(PAYLOAD_DEPTH + 4);
	localparam logic [8:0] MAX_LEN = 9'(PAYLOAD_DEPTH + 1);

	logic [7:0]        footer_q;
	phase_t            phase_q;
	logic [7:0]        len_q;
	logic [FILL_W-1:0] fill_q;
	logic              fwd_q;
	logic [POS_W-1:0]  pos_q;

	logic              out_valid_q;
	phase_t            res_phase_q;
	err_t              res_err_q;
	logic              res_txv_q;
	logic [7:0]        res_txb_q;
	logic              res_last_q;

	phase_t            phase_d;
	logic [7:0]        len_d;
	logic [FILL_W-1:0] fill_d;
	logic [FILL_W-1:0] fill_inc;
	err_t              err_d;
	logic              wr_en;
	logic              fwd_start;

	logic              load;
	logic              in_beat;
	logic              fwd_beat;
	logic [POS_W-1:0]  last_pos;
	logic [POS_W-1:0]  pos_nx;
	logic [POS_W-1:0]  pay_idx;
	logic [7:0]        rd_data;
	logic [7:0]        fwd_byte;

	// handshakes
	assign load     = !out_valid_q || out_ready;
	assign in_ready = !fwd_q && load;
	assign in_beat  = in_valid && in_ready;
	assign fwd_beat = fwd_q && load;
	assign cfg_ready = 1'b1;

	// footer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			footer_q <= FOOTER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			footer_q <= cfg_data;
		end
	end

	// parser next state
	assign fill_inc = fill_q + FILL_W'(1);

	always_comb begin
		phase_d   = phase_q;
		len_d     = len_q;
		fill_d    = fill_q;
		err_d     = ERR_NONE;
		wr_en     = 1'b0;
		fwd_start = 1'b0;
		case (cmd_t'(cmd))
			CMD_RECEIVE: begin
				case (phase_q)
					PH_HDR1: begin
						if (rx_byte == HDR_BYTE) begin
							phase_d = PH_HDR2;
						end
					end
					PH_HDR2: begin
						phase_d = (rx_byte == HDR_BYTE) ? PH_LEN : PH_HDR1;
					end
					PH_LEN: begin
						if (!({1'b0, rx_byte} inside {[9'd1 : MAX_LEN]})) begin
							err_d   = ERR_BAD_LENGTH;
							phase_d = PH_HDR1;
						end else begin
							len_d   = rx_byte;
							fill_d  = '0;
							phase_d = (rx_byte == 8'd1) ? PH_FOOT : PH_DATA;
						end
					end
					PH_DATA: begin
						wr_en  = in_beat;
						fill_d = fill_inc;
						if (9'(fill_inc) + 9'd1 >= {1'b0, len_q}) begin
							phase_d = PH_FOOT;
						end
					end
					PH_FOOT: begin
						if (rx_byte == footer_q) begin
							phase_d = PH_DONE;
						end else begin
							err_d   = ERR_BAD_FOOTER;
							phase_d = PH_HDR1;
						end
					end
					PH_DONE: begin
						err_d = ERR_AFTER_DONE;
					end
					default: begin
						phase_d = PH_HDR1;
					end
				endcase
			end
			CMD_FORWARD: begin
				if (phase_q != PH_DONE) begin
					err_d = ERR_NO_FRAME;
				end else begin
					fwd_start = 1'b1;
				end
			end
			CMD_RESTART: begin
				phase_d = PH_HDR1;
				len_d   = '0;
				fill_d  = '0;
			end
			default: begin
			end
		endcase
	end

	// parser and forward sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR1;
			len_q   <= '0;
			fill_q  <= '0;
			fwd_q   <= 1'b0;
			pos_q   <= '0;
		end else if (in_beat) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			fill_q  <= fill_d;
			if (fwd_start) begin
				fwd_q <= 1'b1;
				pos_q <= '0;
			end
		end else if (fwd_beat) begin
			pos_q <= pos_q + POS_W'(1);
			if (pos_q == last_pos) begin
				fwd_q <= 1'b0;
			end
		end
	end

	// payload read runs one beat ahead of the output register
	assign last_pos = POS_W'(len_q) + POS_W'(2);
	assign pos_nx   = fwd_beat ? pos_q + POS_W'(1) : pos_q;
	assign pay_idx  = pos_nx - POS_W'(3);

	fcr_ram #(
		.WIDTH (8),
		.DEPTH (PAYLOAD_DEPTH)
	) u_payload (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q[ADDR_W-1:0]),
		.wr_data (rx_byte),
		.rd_addr (pay_idx[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// forwarded byte in wire order
	always_comb begin
		if (pos_q < POS_W'(2)) begin
			fwd_byte = HDR_BYTE;
		end else if (pos_q == POS_W'(2)) begin
			fwd_byte = len_q;
		end else if (pos_q == last_pos) begin
			fwd_byte = footer_q;
		end else begin
			fwd_byte = rd_data;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fwd_beat || (in_beat && !fwd_start)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fwd_beat) begin
			res_phase_q <= PH_DONE;
			res_err_q   <= ERR_NONE;
			res_txv_q   <= 1'b1;
			res_txb_q   <= fwd_byte;
			res_last_q  <= (pos_q == last_pos);
		end else if (in_beat && !fwd_start) begin
			res_phase_q <= phase_d;
			res_err_q   <= err_d;
			res_txv_q   <= 1'b0;
			res_txb_q   <= '0;
			res_last_q  <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign phase      = res_phase_q;
	assign frame_done = (res_phase_q == PH_DONE);
	assign error_code = res_err_q;
	assign tx_valid   = res_txv_q;
	assign tx_byte    = res_txb_q;
	assign last       = res_last_q;

	// a forward only runs over a finished frame
	a_fwd_done: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> phase_q == PH_DONE)
		else $error("forward running while frame not finished");

	// a forward starts only from a finished frame
	a_fwd_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fwd_q) |-> $past(phase_q) == PH_DONE)
		else $error("forward started without a frame");

	// forwarded beats carry no error
	a_tx_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid |-> error_code == ERR_NONE && frame_done)
		else $error("forwarded beat with error or not finished");

	// a beat without a forwarded byte closes its run
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> last)
		else $error("non-forward beat without last");

endmodule
